// ===== hw/rtl/iee_pkg.sv =====
// ============================================================================
// iee_pkg: shared types and constants for the infix expression evaluator
// Transaction payloads, character codes and the multiply/divide request codes.
// ============================================================================
`default_nettype none

package iee_pkg;

    // Default fixed-point format: 16 fractional bits in a 64-bit word.
    localparam int FRAC_BITS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 64;

    // ASCII codes of the accepted characters.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Pending multiplicative operator.
    typedef enum logic [1:0] {
        MOP_NONE = 2'd0,
        MOP_MUL  = 2'd1,
        MOP_DIV  = 2'd2
    } t_mop;

    // Input transaction: one character of the expression.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_item;

    // Output transaction: the evaluated expression and its error flags.
    typedef struct packed {
        logic signed [63:0] value;
        logic               div_by_zero;
        logic               bad_char;
        logic               overflow;
    } t_out_item;

    // Status returned by the multiply/divide unit.
    typedef struct packed {
        logic done;
        logic ovf;
        logic div_zero;
    } t_md_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/iee_muldiv.sv =====
// ============================================================================
// iee_muldiv: iterative fixed-point multiply and divide unit
// One shared adder/subtractor does a shift-add multiply or a restoring divide,
// one bit per cycle, with saturation of the fixed-point result.
// ============================================================================
`default_nettype none

module iee_muldiv #(
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire iee_pkg::t_mop          i_op,
    input  wire logic [VALUE_WIDTH-2:0] i_a,
    input  wire logic [VALUE_WIDTH-2:0] i_b,
    output logic      [VALUE_WIDTH-2:0] o_result,
    output iee_pkg::t_md_stat           o_stat
);
    import iee_pkg::*;

    localparam int TW   = VALUE_WIDTH - 1;
    localparam int NUMW = TW + FRAC_BITS;
    localparam int CW   = $clog2(TW + 1);

    logic          r_busy,   n_busy;
    logic          r_is_div, n_is_div;
    logic [CW-1:0] r_cnt,    n_cnt;
    logic [TW-1:0] r_hi,     n_hi;
    logic [TW-1:0] r_lo,     n_lo;
    logic [TW-1:0] r_b,      n_b;
    logic [TW-1:0] r_res,    n_res;
    logic          r_done,   n_done;
    logic          r_ovf,    n_ovf;
    logic          r_dz,     n_dz;

    logic [NUMW-1:0] num;
    logic [TW:0]     num_hi;
    logic [TW:0]     add_x;
    logic [TW+1:0]   add_y;
    logic [TW+1:0]   add_sum;
    logic            div_ge;
    logic [2*TW-1:0] prod;
    logic            prod_ovf;

    // Dividend scaled by the fraction bits, split at the quotient width.
    assign num    = NUMW'(i_a) << FRAC_BITS;
    assign num_hi = (TW + 1)'(num >> TW);

    // The shared adder: accumulate the multiplicand, or trial-subtract the divisor.
    always_comb begin
        if (r_is_div) begin
            add_x   = {r_hi, r_lo[TW-1]};
            add_y   = ~{2'b00, r_b};
            add_sum = {1'b0, add_x} + add_y + (TW + 2)'(1);
        end else begin
            add_x   = {1'b0, r_hi};
            add_y   = r_lo[0] ? {2'b00, r_b} : '0;
            add_sum = {1'b0, add_x} + add_y;
        end
    end

    assign div_ge   = ~add_sum[TW+1];
    assign prod     = {r_hi, r_lo};
    assign prod_ovf = (prod >> (FRAC_BITS + TW)) != '0;

    always_comb begin
        n_busy   = r_busy;
        n_is_div = r_is_div;
        n_cnt    = r_cnt;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_b      = r_b;
        n_res    = r_res;
        n_done   = 1'b0;
        n_ovf    = r_ovf;
        n_dz     = r_dz;

        if (i_start) begin
            n_is_div = (i_op == MOP_DIV);
            n_ovf    = 1'b0;
            n_dz     = 1'b0;
            n_cnt    = CW'(TW);
            if (i_op != MOP_DIV) begin
                n_hi   = '0;
                n_lo   = i_b;
                n_b    = i_a;
                n_busy = 1'b1;
            end else if (i_b == '0) begin
                // Zero divisor: maximum for a nonzero dividend, else zero.
                n_dz   = 1'b1;
                n_res  = (i_a != '0) ? '1 : '0;
                n_done = 1'b1;
            end else if (num_hi >= {1'b0, i_b}) begin
                // Quotient cannot fit in the value range.
                n_ovf  = 1'b1;
                n_res  = '1;
                n_done = 1'b1;
            end else begin
                n_hi   = TW'(num_hi);
                n_lo   = TW'(num);
                n_b    = i_b;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_cnt = r_cnt - CW'(1);
                if (r_is_div) begin
                    n_hi = div_ge ? add_sum[TW-1:0] : add_x[TW-1:0];
                    n_lo = {r_lo[TW-2:0], div_ge};
                end else begin
                    n_hi = add_sum[TW:1];
                    n_lo = {add_sum[0], r_lo[TW-1:1]};
                end
            end else begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (r_is_div) begin
                    n_res = r_lo;
                end else begin
                    n_ovf = prod_ovf;
                    n_res = prod_ovf ? '1 : TW'(prod >> FRAC_BITS);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_dz   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_ovf  <= n_ovf;
            r_dz   <= n_dz;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_div <= n_is_div;
        r_cnt    <= n_cnt;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_b      <= n_b;
        r_res    <= n_res;
    end

    assign o_result        = r_res;
    assign o_stat.done     = r_done;
    assign o_stat.ovf      = r_ovf;
    assign o_stat.div_zero = r_dz;

endmodule

`default_nettype wire

// ===== hw/rtl/infix_expression_evaluator_core.sv =====
// ============================================================================
// infix_expression_evaluator_core: streaming infix arithmetic evaluator
// Folds one ASCII character per transaction into a fixed-point result.
// ============================================================================
// The block reads an expression of unsigned decimal numbers and the operators
// + - * / one character per input transaction, with * and / binding tighter
// than + and -, both levels evaluated left to right. The character marked
// last closes the expression and produces one output transaction carrying a
// signed fixed-point value (FRAC_BITS fractional bits, saturated to
// VALUE_WIDTH bits, sign extended to 64) and three sticky error flags.
// A digit or an unknown character is decoded and the block returns to idle. A
// * or / that opens a term passes through the number stage, and a + or - that
// follows a plain number also passes through the sum stage. An operator that
// closes a product or quotient waits on the iterative multiply/divide unit,
// which handles one bit per cycle, and a + or - then also passes through the
// sum stage; a zero divisor or an out-of-range quotient is detected up front.
// The closing character adds one more pass through the number and sum stages
// before the result is offered. The block holds ready low while it works on a
// transaction and while a result waits.
// ============================================================================
`default_nettype none

module infix_expression_evaluator_core #(
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire iee_pkg::t_in_item i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output iee_pkg::t_out_item     o_data
);
    import iee_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int TW = VW - 1;
    // Integer digits that fit in the format; at least one bit of storage.
    localparam int NW = (VW - 1 - FRAC_BITS > 0) ? (VW - 1 - FRAC_BITS) : 1;
    localparam logic [63:0] VMAX64 = (64'd1 << (VW - 1)) - 64'd1;
    localparam logic [63:0] NMAX64 = VMAX64 >> FRAC_BITS;
    localparam logic [NW+3:0] NMAX_W = (NW + 4)'(NMAX64);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_NUM    = 6'b000100,
        ST_WAIT   = 6'b001000,
        ST_TERM   = 6'b010000,
        ST_OUT    = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    t_in_item             r_in,    n_in;
    logic                 r_final, n_final;
    logic signed [VW-1:0] r_sum,   n_sum;
    logic [TW-1:0]        r_term,  n_term;
    logic [NW-1:0]        r_acc,   n_acc;
    logic                 r_aop,   n_aop;
    t_mop                 r_mop,   n_mop;
    logic                 r_dz,    n_dz;
    logic                 r_bad,   n_bad;
    logic                 r_ovf,   n_ovf;
    t_out_item            r_out,   n_out;

    // Multiply/divide unit interface.
    logic          md_start;
    logic [TW-1:0] md_result;
    t_md_stat      md_stat;
    logic [TW-1:0] operand;

    // Digit accumulation.
    logic [NW+3:0] dec;
    logic          dec_ovf;

    // Add or subtract of the finished term into the running sum.
    logic signed [VW:0]   sum_ext;
    logic                 sum_ovf;
    logic signed [VW-1:0] sum_sat;

    // Where to go once the current number has been folded into the term.
    t_state post_state;
    t_mop   post_mop;
    logic   post_final;

    // The completed number as a fixed-point operand.
    assign operand = TW'(r_acc) << FRAC_BITS;

    // accum * 10 + digit, saturating at the largest integer the format holds.
    assign dec = ((NW + 4)'(r_acc) << 3) + ((NW + 4)'(r_acc) << 1)
               + (NW + 4)'(r_in.ch[3:0]);
    assign dec_ovf = dec > NMAX_W;

    // The term is never negative, so plus can only overflow upward and
    // minus only downward; the sign of the wide result picks the limit.
    assign sum_ext = r_aop ? ({r_sum[VW-1], r_sum} - {2'b00, r_term})
                           : ({r_sum[VW-1], r_sum} + {2'b00, r_term});
    assign sum_ovf = sum_ext[VW] != sum_ext[VW-1];
    always_comb begin
        if (!sum_ovf) begin
            sum_sat = sum_ext[VW-1:0];
        end else if (sum_ext[VW]) begin
            sum_sat = {1'b1, {TW{1'b0}}};
        end else begin
            sum_sat = {1'b0, {TW{1'b1}}};
        end
    end

    // After a number is folded: a * or / records its operator, a + or -
    // goes on to close the term, and the closing pass always closes it.
    always_comb begin
        post_state = ST_TERM;
        post_mop   = MOP_NONE;
        post_final = r_final;
        if (!r_final) begin
            case (r_in.ch)
                CH_STAR: begin
                    post_mop   = MOP_MUL;
                    post_state = r_in.last ? ST_NUM : ST_IDLE;
                    post_final = r_in.last;
                end
                CH_SLASH: begin
                    post_mop   = MOP_DIV;
                    post_state = r_in.last ? ST_NUM : ST_IDLE;
                    post_final = r_in.last;
                end
                default: begin
                    post_state = ST_TERM;
                end
            endcase
        end
    end

    always_comb begin
        n_state  = r_state;
        n_in     = r_in;
        n_final  = r_final;
        n_sum    = r_sum;
        n_term   = r_term;
        n_acc    = r_acc;
        n_aop    = r_aop;
        n_mop    = r_mop;
        n_dz     = r_dz;
        n_bad    = r_bad;
        n_ovf    = r_ovf;
        n_out    = r_out;
        md_start = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_in    = i_data;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (r_in.ch) inside
                    [CH_ZERO:CH_NINE]: begin
                        n_acc   = dec_ovf ? NW'(NMAX64) : dec[NW-1:0];
                        n_ovf   = r_ovf | dec_ovf;
                        n_final = 1'b1;
                        n_state = r_in.last ? ST_NUM : ST_IDLE;
                    end
                    CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS: begin
                        n_final = 1'b0;
                        n_state = ST_NUM;
                    end
                    default: begin
                        // Unknown characters are flagged and otherwise skipped.
                        n_bad   = 1'b1;
                        n_final = 1'b1;
                        n_state = r_in.last ? ST_NUM : ST_IDLE;
                    end
                endcase
            end
            ST_NUM: begin
                if (r_mop == MOP_NONE) begin
                    n_term  = operand;
                    n_acc   = '0;
                    n_mop   = post_mop;
                    n_final = post_final;
                    n_state = post_state;
                end else begin
                    md_start = 1'b1;
                    n_state  = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (md_stat.done) begin
                    n_term  = md_result;
                    n_ovf   = r_ovf | md_stat.ovf;
                    n_dz    = r_dz | md_stat.div_zero;
                    n_acc   = '0;
                    n_mop   = post_mop;
                    n_final = post_final;
                    n_state = post_state;
                end
            end
            ST_TERM: begin
                if (r_final) begin
                    // Close the expression and return the running registers to their reset values.
                    n_out.value       = 64'(sum_sat);
                    n_out.div_by_zero = r_dz;
                    n_out.bad_char    = r_bad;
                    n_out.overflow    = r_ovf | sum_ovf;
                    n_sum             = '0;
                    n_term            = '0;
                    n_acc             = '0;
                    n_aop             = 1'b0;
                    n_mop             = MOP_NONE;
                    n_dz              = 1'b0;
                    n_bad             = 1'b0;
                    n_ovf             = 1'b0;
                    n_final           = 1'b0;
                    n_state           = ST_OUT;
                end else begin
                    n_sum   = sum_sat;
                    n_ovf   = r_ovf | sum_ovf;
                    n_term  = '0;
                    n_aop   = (r_in.ch == CH_MINUS);
                    n_final = r_in.last;
                    n_state = r_in.last ? ST_NUM : ST_IDLE;
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_final <= 1'b0;
            r_sum   <= '0;
            r_term  <= '0;
            r_acc   <= '0;
            r_aop   <= 1'b0;
            r_mop   <= MOP_NONE;
            r_dz    <= 1'b0;
            r_bad   <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
            r_sum   <= n_sum;
            r_term  <= n_term;
            r_acc   <= n_acc;
            r_aop   <= n_aop;
            r_mop   <= n_mop;
            r_dz    <= n_dz;
            r_bad   <= n_bad;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    iee_muldiv #(
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (md_start),
        .i_op     (r_mop),
        .i_a      (r_term),
        .i_b      (operand),
        .o_result (md_result),
        .o_stat   (md_stat)
    );

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_data  = r_out;

endmodule

`default_nettype wire
